/* rtl/core/fadd_pkg.sv */
// ----------------------------------------------------------------------------
// fadd_pkg
// shared types and constants of the single-precision adder pipeline
// ----------------------------------------------------------------------------
package fadd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned MANT_W = 27;
    localparam int unsigned SHIFT_W = 5;

    localparam logic [WORD_W-1:0] DEFAULT_NAN = 32'hffc0_0000;
    localparam logic [WORD_W-1:0] INF_BITS = 32'h7f80_0000;
    localparam logic [WORD_W-1:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [EXP_W-1:0] EXP_MAX = 8'hff;

    typedef struct packed {
        logic                  special;
        logic [WORD_W-1:0]     special_bits;
        logic                  sign;
        logic                  sub;
        logic [EXP_W-1:0]      exp;
        logic [MANT_W-1:0]     ma;
        logic [MANT_W-1:0]     mb;
    } align_t;

    typedef struct packed {
        logic                  special;
        logic [WORD_W-1:0]     special_bits;
        logic                  sign;
        logic [EXP_W+1:0]      exp;
        logic [MANT_W-1:0]     mant;
    } norm_t;

endpackage

/* rtl/core/float32_adder_flush_denormals_core.sv */
// ----------------------------------------------------------------------------
// float32_adder_flush_denormals_core
// single-precision adder, denormals flushed, round to nearest-even
// a request passes the align, norm and round stage registers in turn to result valid
// throughput: one request per cycle while the output is not stalled, set by the three-stage pipeline
// a stalled output freezes all stages together
// reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module float32_adder_flush_denormals_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata    // sum_bits [31:0]
);
    import fadd_pkg::*;

    logic en;
    logic v1;
    logic v2;
    align_t d1;
    norm_t d2;

    assign en = m_tready || !m_tvalid;
    assign s_tready = en;

    fadd_align u_align
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .operand_a (s_tdata[31:0]),
        .operand_b (s_tdata[63:32]),
        .out_valid (v1),
        .out_data  (d1)
    );

    fadd_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    fadd_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (m_tvalid),
        .out_bits  (m_tdata)
    );
endmodule

/* rtl/core/fadd_align.sv */
// ----------------------------------------------------------------------------
// fadd_align
// special-case detection, magnitude ordering and mantissa alignment
// ----------------------------------------------------------------------------
module fadd_align
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [fadd_pkg::WORD_W-1:0]  operand_a,
    input  logic [fadd_pkg::WORD_W-1:0]  operand_b,
    output logic                         out_valid,
    output fadd_pkg::align_t             out_data
);
    import fadd_pkg::*;

    logic [EXP_W-1:0] ea;
    logic [EXP_W-1:0] eb;
    logic nan_a;
    logic nan_b;
    logic swap;
    logic [WORD_W-1:0] big;
    logic [WORD_W-1:0] small_op;
    logic [EXP_W-1:0] diff;
    logic [MANT_W-1:0] mb_full;
    logic [MANT_W-1:0] mb_shift;
    logic [MANT_W-1:0] lost_mask;
    align_t data_next;
    align_t data_reg;
    logic valid_reg;

    always_comb
    begin
        ea = operand_a[30:23];
        eb = operand_b[30:23];
        nan_a = (ea == EXP_MAX) && (operand_a[22:0] != '0);
        nan_b = (eb == EXP_MAX) && (operand_b[22:0] != '0);
        swap = operand_a[30:0] < operand_b[30:0];
        big = swap ? operand_b : operand_a;
        small_op = swap ? operand_a : operand_b;
        diff = big[30:23] - small_op[30:23];
        mb_full = {1'b1, small_op[22:0], 3'b000};
        lost_mask = ~({MANT_W{1'b1}} << diff[SHIFT_W-1:0]);
        mb_shift = mb_full >> diff[SHIFT_W-1:0];
        data_next.special = 1'b1;
        data_next.special_bits = '0;
        data_next.sign = big[31];
        data_next.sub = big[31] != small_op[31];
        data_next.exp = big[30:23];
        data_next.ma = {1'b1, big[22:0], 3'b000};
        if (diff >= 8'd27)
        begin
            data_next.mb = {{(MANT_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            data_next.mb = mb_shift | {{(MANT_W-1){1'b0}}, |(mb_full & lost_mask)};
        end
        if (ea == EXP_MAX || eb == EXP_MAX)
        begin
            if (nan_a)
            begin
                data_next.special_bits = operand_a | QUIET_BIT;
            end
            else if (nan_b)
            begin
                data_next.special_bits = operand_b | QUIET_BIT;
            end
            else if (ea == EXP_MAX && eb == EXP_MAX)
            begin
                data_next.special_bits = (operand_a == operand_b) ? operand_a : DEFAULT_NAN;
            end
            else
            begin
                data_next.special_bits = (ea == EXP_MAX) ? operand_a : operand_b;
            end
        end
        else if (ea == '0 || eb == '0)
        begin
            if (ea == '0 && eb == '0)
            begin
                data_next.special_bits = operand_a & operand_b & 32'h8000_0000;
            end
            else
            begin
                data_next.special_bits = (ea == '0) ? operand_b : operand_a;
            end
        end
        else
        begin
            data_next.special = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
endmodule

/* rtl/core/fadd_norm.sv */
// ----------------------------------------------------------------------------
// fadd_norm
// mantissa add or subtract and leading-one normalization
// ----------------------------------------------------------------------------
module fadd_norm
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  fadd_pkg::align_t  in_data,
    output logic              out_valid,
    output fadd_pkg::norm_t   out_data
);
    import fadd_pkg::*;

    logic [MANT_W:0] sum;
    logic [MANT_W-1:0] diffm;
    logic [SHIFT_W-1:0] lz;
    logic found;
    norm_t data_next;
    norm_t data_reg;
    logic valid_reg;

    always_comb
    begin
        sum = {1'b0, in_data.ma} + {1'b0, in_data.mb};
        diffm = in_data.ma - in_data.mb;
        lz = '0;
        found = 1'b0;
        for (int i = MANT_W - 1; i >= 0; i--)
        begin
            if (!found && diffm[i])
            begin
                found = 1'b1;
                lz = SHIFT_W'(MANT_W - 1 - i);
            end
        end
        data_next.special = in_data.special;
        data_next.special_bits = in_data.special_bits;
        data_next.sign = in_data.sign;
        data_next.exp = {2'b00, in_data.exp};
        data_next.mant = in_data.ma;
        if (!in_data.special)
        begin
            if (!in_data.sub)
            begin
                if (sum[MANT_W])
                begin
                    data_next.exp = {2'b00, in_data.exp} + 10'd1;
                    data_next.mant = sum[MANT_W:1] | {{(MANT_W-1){1'b0}}, sum[0]};
                end
                else
                begin
                    data_next.mant = sum[MANT_W-1:0];
                end
            end
            else if (diffm == '0)
            begin
                data_next.special = 1'b1;
                data_next.special_bits = '0;
            end
            else if ({2'b00, in_data.exp} <= {5'd0, lz})
            begin
                data_next.special = 1'b1;
                data_next.special_bits = {in_data.sign, 31'd0};
            end
            else
            begin
                data_next.exp = {2'b00, in_data.exp} - {5'd0, lz};
                data_next.mant = diffm << lz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
endmodule

/* rtl/core/fadd_round.sv */
// ----------------------------------------------------------------------------
// fadd_round
// nearest-even rounding, overflow and underflow, result packing
// ----------------------------------------------------------------------------
module fadd_round
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  fadd_pkg::norm_t              in_data,
    output logic                         out_valid,
    output logic [fadd_pkg::WORD_W-1:0]  out_bits
);
    import fadd_pkg::*;

    logic [MANT_W:0] rnd;
    logic [MANT_W-1:0] mant;
    logic [EXP_W+1:0] e;
    logic [WORD_W-1:0] bits_next;
    logic [WORD_W-1:0] bits_reg;
    logic valid_reg;

    always_comb
    begin
        mant = in_data.mant;
        e = in_data.exp;
        rnd = {1'b0, mant} + 28'd8;
        if (mant[2] && (mant[3] || mant[1] || mant[0]))
        begin
            if (rnd[MANT_W])
            begin
                e = in_data.exp + 10'd1;
                mant = rnd[MANT_W:1];
            end
            else
            begin
                mant = rnd[MANT_W-1:0];
            end
        end
        if (in_data.special)
        begin
            bits_next = in_data.special_bits;
        end
        else if (e >= 10'd255)
        begin
            bits_next = {in_data.sign, 31'd0} | INF_BITS;
        end
        else if (e == '0)
        begin
            bits_next = {in_data.sign, 31'd0};
        end
        else
        begin
            bits_next = {in_data.sign, e[EXP_W-1:0], mant[FRAC_W+2:3]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bits_reg <= bits_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bits = bits_reg;
endmodule

/* tb/float32_adder_flush_denormals_core_tb.sv */
// ----------------------------------------------------------------------------
// float32_adder_flush_denormals_core_tb
// drives operand pairs through the stream interface with random gaps on
// both sides and compares every sum with a bit-exact software adder
// ----------------------------------------------------------------------------
module float32_adder_flush_denormals_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] FRAC_BITS = 32'h007f_ffff;
    localparam logic [7:0] EXP_TOP = 8'hff;
    localparam logic [31:0] NAN_DEFAULT = 32'hffc0_0000;
    localparam logic [31:0] INF_PATTERN = 32'h7f80_0000;
    localparam logic [31:0] QUIET_MASK = 32'h0040_0000;
    localparam logic [27:0] MANT_ONE = 28'h400_0000;
    localparam logic [27:0] MANT_CARRY = 28'h800_0000;
    localparam int RANDOM_REQUESTS = 1030;
    localparam int CYCLE_LIMIT = 200000;

    function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
        logic [7:0] ea;
        logic [7:0] eb;
        logic [31:0] t;
        logic [31:0] sgn;
        logic [9:0] e;
        logic [7:0] diff;
        logic [27:0] ma;
        logic [27:0] mb;
        logic [27:0] lost;
        ea = a[30:23];
        eb = b[30:23];
        if (ea == EXP_TOP || eb == EXP_TOP)
        begin
            if (ea == EXP_TOP && (a & FRAC_BITS) != 0)
                return a | QUIET_MASK;
            if (eb == EXP_TOP && (b & FRAC_BITS) != 0)
                return b | QUIET_MASK;
            if (ea == EXP_TOP && eb == EXP_TOP)
                return (a == b) ? a : NAN_DEFAULT;
            return (ea == EXP_TOP) ? a : b;
        end
        if (ea == 0 || eb == 0)
        begin
            if (ea == 0 && eb == 0)
                return a & b & SIGN_BIT;
            return (ea == 0) ? b : a;
        end
        if ((a & ~SIGN_BIT) < (b & ~SIGN_BIT))
        begin
            t = a;
            a = b;
            b = t;
            ea = a[30:23];
            eb = b[30:23];
        end
        sgn = a & SIGN_BIT;
        e = {2'b00, ea};
        diff = ea - eb;
        ma = MANT_ONE | {2'b00, a[22:0], 3'b000};
        mb = MANT_ONE | {2'b00, b[22:0], 3'b000};
        if (diff >= 27)
            mb = 28'd1;
        else if (diff > 0)
        begin
            lost = mb & ((28'd1 << diff) - 28'd1);
            mb = (mb >> diff) | {27'd0, lost != 0};
        end
        if (a[31] == b[31])
        begin
            ma = ma + mb;
            if ((ma & MANT_CARRY) != 0)
            begin
                e = e + 10'd1;
                ma = (ma >> 1) | {27'd0, ma[0]};
            end
        end
        else
        begin
            ma = ma - mb;
            if (ma == 0)
                return 32'd0;
            while ((ma & MANT_ONE) == 0)
            begin
                if (e == 0)
                    return sgn;
                e = e - 10'd1;
                ma = ma << 1;
            end
        end
        if (ma[2] && (ma[3] || ma[1] || ma[0]))
        begin
            ma = ma + 28'd8;
            if ((ma & MANT_CARRY) != 0)
            begin
                e = e + 10'd1;
                ma = ma >> 1;
            end
        end
        if (e >= 255)
            return sgn | INF_PATTERN;
        if (e == 0)
            return sgn;
        return sgn | {1'b0, e[7:0], ma[25:3]};
    endfunction

    class sum_scoreboard;
        logic [31:0] pending_sums[$];
        logic [63:0] pending_ops[$];
        int errors;
        int checked;

        function void note_request(logic [31:0] a, logic [31:0] b);
            pending_sums.push_back(float_sum(a, b));
            pending_ops.push_back({b, a});
        endfunction

        function void check_sum(logic [31:0] got);
            logic [31:0] want;
            logic [63:0] ops;
            if (pending_sums.size() == 0)
            begin
                report_error($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_sums.pop_front();
            ops = pending_ops.pop_front();
            checked++;
            if (got !== want)
                report_error($sformatf("a=%h b=%h sum %h, want %h",
                    ops[31:0], ops[63:32], got, want));
        endfunction

        function void report_error(string msg);
            errors++;
            if (errors <= 30)
                $display("ERROR: %s", msg);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;   // operand_a [31:0], operand_b [63:32]
    logic m_tvalid;
    logic m_tready;
    logic [31:0] m_tdata;   // sum_bits [31:0]

    sum_scoreboard sums;
    int cycles;
    int sent;

    float32_adder_flush_denormals_core i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [31:0] random_float();
        logic [31:0] v;
        int r;
        v = $urandom;
        r = $urandom_range(0, 99);
        if (r < 8)
            v[30:23] = 8'h00;
        else if (r < 16)
            v[30:23] = EXP_TOP;
        else if (r < 22)
            v[30:23] = $urandom_range(0, 1) ? 8'hfe : 8'h01;
        else if (r < 28)
            v[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7fffff;
        return v;
    endfunction

    task automatic send_request(logic [31:0] a, logic [31:0] b);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sums.note_request(a, b);
        sent++;
    endtask

    task automatic send_near(logic [31:0] a);
        logic [31:0] b;
        b = a;
        b[31] = 1'($urandom_range(0, 1));
        b[30:23] = 8'(a[30:23] - $urandom_range(0, 2) + $urandom_range(0, 30));
        if (b[30:23] == EXP_TOP)
            b[30:23] = a[30:23];
        b[22:0] = $urandom_range(0, 1) ? 23'(a[22:0] ^ ($urandom & 32'h1f)) : 23'($urandom);
        send_request(a, b);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sums.check_sum(m_tdata);
            if (cycles > 4000 && cycles < 4600)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) < 8) ? 1'b0 :
                            ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] directed[$];
        sums = new();
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nan, infinity, zero, denormal, extremes
        directed = '{32'h7fc00001, 32'h7f800001, 32'hff800000, 32'h7f800000,
                     32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff,
                     32'h7f7fffff, 32'hff7fffff, 32'h00800000, 32'h80800000,
                     32'h3f800000};
        send_request(32'h7f800001, 32'hffc00005);
        send_request(32'h3f800000, 32'h7fa00000);
        send_request(32'h7f800000, 32'hff800000);
        send_request(32'hff800000, 32'hff800000);
        send_request(32'h7f800000, 32'h3f800000);
        send_request(32'h80000000, 32'h80000000);
        send_request(32'h80000000, 32'h00000000);
        send_request(32'h00000001, 32'h807fffff);
        send_request(32'h00000003, 32'h40490fdb);
        send_request(32'h3f800000, 32'hbf800000);
        send_request(32'h00800000, 32'h80800001);
        send_request(32'h00ffffff, 32'h80800000);
        send_request(32'h7f7fffff, 32'h7f7fffff);
        send_request(32'hff7fffff, 32'hff000000);
        send_request(32'h3f800000, 32'h33800000);
        send_request(32'h3f800001, 32'h33800000);
        send_request(32'h3f800000, 32'h00800000);
        send_request(32'hffffffff, 32'hffffffff);
        send_request(32'h4b7fffff, 32'h3f000000);
        send_request(32'h3fffffff, 32'hbf800001);
        foreach (directed[i])
            send_request(directed[i], directed[(i + 5) % directed.size()]);
        s_tvalid <= 1'b0;

        // hold off until the pipeline drains
        while (sums.pending_sums.size() != 0)
            @(posedge clk);

        repeat (RANDOM_REQUESTS)
        begin
            a = random_float();
            if ($urandom_range(0, 99) < 40)
                send_near(a);
            else
                send_request(a, random_float());
        end
        s_tvalid <= 1'b0;

        while (sums.pending_sums.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        $display("covered %0d requests, %0d sums checked, incl. nan, inf, zero,",
                 sent, sums.checked);
        $display("denormal flush, cancellation, overflow and rounding cases");
        if (sums.errors == 0 && sums.pending_sums.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/fadd_pkg.sv
rtl/core/fadd_align.sv
rtl/core/fadd_norm.sv
rtl/core/fadd_round.sv
rtl/core/float32_adder_flush_denormals_core.sv
tb/float32_adder_flush_denormals_core_tb.sv
